// ===== hw/rtl/trrd_pkg.sv =====
// Package for the text region run detector: sizes, item types, command and
// status structs between controller and datapath, and byte class functions.
// Depends on nothing; every other file imports it.
`default_nettype none

package trrd_pkg;

	localparam int BLOCK_BYTES  = 4096;
	localparam int SAMPLE_BYTES = 512;
	localparam int OFFSET_BITS  = 32;

	localparam int SAMPLE_TAKE = (SAMPLE_BYTES < BLOCK_BYTES) ? SAMPLE_BYTES : BLOCK_BYTES;
	localparam int BLK_W       = $clog2(BLOCK_BYTES);
	localparam int SMP_W       = $clog2(SAMPLE_TAKE);
	localparam int CNT_W       = SMP_W + 1;
	localparam int MAX_RESULTS = 64;
	localparam int RES_W       = $clog2(MAX_RESULTS) + 1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam int PCT_W      = 7;
	localparam int MINB_W     = 13;
	localparam int MINW_W     = 12;

	localparam logic [CFG_IDX_W-1:0] REG_PRINT_MAIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRINT_ALT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_ALT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_B64    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDE   = 3'd4;

	localparam logic [1:0] KIND_REGION = 2'd0;
	localparam logic [1:0] KIND_B64    = 2'd1;
	localparam logic [1:0] KIND_WIDE   = 2'd2;

	localparam logic [3:0] OP_NONE         = 4'd0;
	localparam logic [3:0] OP_ACCEPT       = 4'd1;
	localparam logic [3:0] OP_JUDGE        = 4'd2;
	localparam logic [3:0] OP_READ         = 4'd3;
	localparam logic [3:0] OP_FEED_B64     = 4'd4;
	localparam logic [3:0] OP_FEED_WIDE    = 4'd5;
	localparam logic [3:0] OP_CLOSE_B64    = 4'd6;
	localparam logic [3:0] OP_CLOSE_WIDE   = 4'd7;
	localparam logic [3:0] OP_CLOSE_REGION = 4'd8;
	localparam logic [3:0] OP_FINISH       = 4'd9;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] start_offset;
		logic [31:0] length_bytes;
		logic        last_of_batch;
	} out_item_t;

	typedef struct packed {
		logic [3:0] op;
		logic       replay;
	} cmd_t;

	typedef struct packed {
		logic sample_done;
		logic direct_feed;
		logic text;
		logic region_open;
		logic eof;
		logic more;
	} stat_t;

	function automatic logic is_b64(input logic [7:0] b);
		return (b inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39], 8'h2B, 8'h2F, 8'h3D});
	endfunction

	function automatic logic is_print(input logic [7:0] b);
		return (b inside {[8'h20:8'h7E]});
	endfunction

	function automatic logic is_texty(input logic [7:0] b);
		return (b inside {8'h09, 8'h0A, 8'h0D, [8'h20:8'h7E]});
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/text_region_run_detector_unit.sv =====
// Text region run detector, top level. Each byte is accepted and finished; outside
// a sample, inside a region, it also feeds the run trackers (base64 step, UTF-16LE
// step). The byte completing a sample adds a verdict step and, per replayed byte,
// a memory read, base64 step and UTF-16LE step; closing a region adds base64,
// UTF-16LE and region closing steps, and a second finish when the file ends inside
// it. Every step waits while a finished item sits unclaimed. Reset clears all state
// and restores the register defaults; the sample memory is not cleared.
`default_nettype none

module text_region_run_detector_unit import trrd_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire in_item_t              in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_item_t                  out_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t  cmd;
	stat_t stat;
	logic  adv;

	assign adv = !out_valid || out_ready;

	trrd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.adv      (adv),
		.stat     (stat),
		.cmd      (cmd)
	);

	trrd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again in the cycle after an accept");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.kind != 2'd3)
		else $error("descriptor kind out of range");

	a_ready_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!out_valid || out_ready))
		else $error("input taken while output register is blocked");

endmodule

`default_nettype wire

// ===== hw/rtl/trrd_ctrl.sv =====
// Controller of the text region run detector: sequences accept, verdict,
// replay, run closing and item finish. Imports trrd_pkg.
`default_nettype none

module trrd_ctrl import trrd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire logic  adv,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_JUDGE = 4'd1;
	localparam logic [3:0] S_READ  = 4'd2;
	localparam logic [3:0] S_FB    = 4'd3;
	localparam logic [3:0] S_FW    = 4'd4;
	localparam logic [3:0] S_CB    = 4'd5;
	localparam logic [3:0] S_CW    = 4'd6;
	localparam logic [3:0] S_CR    = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;

	logic [3:0] state_q, state_d;
	logic       replay_q, replay_d;
	logic [3:0] op;

	assign in_ready = (state_q == S_IDLE) && adv;

	always_comb begin
		op       = OP_NONE;
		state_d  = state_q;
		replay_d = replay_q;
		if (adv) begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op = OP_ACCEPT;
						replay_d = 1'b0;
						if (stat.sample_done) state_d = S_JUDGE;
						else if (stat.direct_feed) state_d = S_FB;
						else state_d = S_FIN;
					end
				end
				S_JUDGE: begin
					op = OP_JUDGE;
					if (stat.text) begin
						replay_d = 1'b1;
						state_d  = S_READ;
					end else if (stat.region_open) state_d = S_CB;
					else state_d = S_FIN;
				end
				S_READ: begin
					op = OP_READ;
					state_d = S_FB;
				end
				S_FB: begin
					op = OP_FEED_B64;
					state_d = S_FW;
				end
				S_FW: begin
					op = OP_FEED_WIDE;
					if (replay_q && stat.more) state_d = S_READ;
					else state_d = S_FIN;
				end
				S_CB: begin
					op = OP_CLOSE_B64;
					state_d = S_CW;
				end
				S_CW: begin
					op = OP_CLOSE_WIDE;
					state_d = S_CR;
				end
				S_CR: begin
					op = OP_CLOSE_REGION;
					state_d = S_FIN;
				end
				S_FIN: begin
					op = OP_FINISH;
					// A file that ends inside a region closes it before finishing.
					if (stat.eof && stat.region_open) state_d = S_CB;
					else state_d = S_IDLE;
				end
				default: state_d = S_IDLE;
			endcase
		end
	end

	assign cmd.op     = op;
	assign cmd.replay = replay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			replay_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			replay_q <= replay_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/trrd_dp.sv =====
// Datapath of the text region run detector: sample memory, block verdict,
// base64 and UTF-16LE run trackers, descriptor holding and output register.
// Imports trrd_pkg; driven by trrd_ctrl commands.
`default_nettype none

module trrd_dp import trrd_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	output stat_t                      stat,
	input  wire in_item_t              in_data,
	input  wire logic                  out_ready,
	output logic                       out_valid,
	output out_item_t                  out_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int OFS_W = OFFSET_BITS;
	localparam int MUL_W = CNT_W + PCT_W;
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_LOW  = 2'd1;
	localparam logic [1:0] PH_PAIR = 2'd2;

	logic [PCT_W-1:0]  main_q, alt_q, zero_q;
	logic [MINB_W-1:0] minb_q;
	logic [MINW_W-1:0] minw_q;

	logic [7:0]       mem [SAMPLE_TAKE];
	logic [7:0]       rdata_q;
	logic [OFS_W-1:0] pos_q, rbeg_q, bbeg_q, wbeg_q, rpos_q, cend_q;
	logic [BLK_W-1:0] k_q;
	logic [CNT_W-1:0] pc_q, zc_q;
	logic             open_q, skip_q, bact_q, eof_q, pend_v_q, out_v_q;
	logic [MINW_W-1:0] wch_q;
	logic [1:0]       wph_q;
	logic [7:0]       byte_q;
	logic [SMP_W-1:0] i_q;
	logic [RES_W-1:0] cnt_q;
	out_item_t        pend_q, out_q;

	logic             k_first, in_sample, sample_last;
	logic [CNT_W-1:0] pc_base, zc_base, take;
	logic [MUL_W-1:0] p100, z100;
	logic             text;
	logic [OFS_W-1:0] bstart, fpos, blen, cblen, wend, wlen, rlen;
	logic [7:0]       fb;
	logic             fb_b64, fb_print, wrep;
	logic             emit_req;
	logic [1:0]       emit_kind;
	logic [OFS_W-1:0] emit_start, emit_len;
	logic             fin_close;
	out_item_t        new_item;

	assign k_first     = (k_q == '0);
	assign in_sample   = {1'b0, k_q} < (BLK_W+1)'(SAMPLE_TAKE);
	assign sample_last = ({1'b0, k_q} + 1'b1) == (BLK_W+1)'(SAMPLE_TAKE);
	assign pc_base     = k_first ? '0 : pc_q;
	assign zc_base     = k_first ? '0 : zc_q;

	assign take = CNT_W'(k_q) + 1'b1;
	assign p100 = MUL_W'(pc_q) * MUL_W'(100);
	assign z100 = MUL_W'(zc_q) * MUL_W'(100);
	assign text = (p100 >= MUL_W'(take) * MUL_W'(main_q)) ||
		((p100 >= MUL_W'(take) * MUL_W'(alt_q)) && (z100 >= MUL_W'(take) * MUL_W'(zero_q)));

	assign bstart   = pos_q - OFS_W'(k_q);
	assign fb       = cmd.replay ? rdata_q : byte_q;
	assign fpos     = cmd.replay ? rpos_q : pos_q;
	assign fb_b64   = is_b64(fb);
	assign fb_print = is_print(fb);
	assign blen     = fpos - bbeg_q;
	assign cblen    = cend_q - bbeg_q;
	assign rlen     = cend_q - rbeg_q;
	assign wrep     = (wch_q != '0) && (wch_q >= minw_q);
	assign fin_close = eof_q && open_q;

	// A run still waiting for its closing zero ends one byte earlier.
	always_comb begin
		if (cmd.op == OP_FEED_WIDE) wend = (wph_q == PH_LOW) ? fpos - 1'b1 : fpos;
		else wend = (wph_q == PH_PAIR) ? cend_q : cend_q - 1'b1;
	end
	assign wlen = wend - wbeg_q;

	always_comb begin
		emit_req   = 1'b0;
		emit_kind  = KIND_REGION;
		emit_start = rbeg_q;
		emit_len   = rlen;
		case (cmd.op)
			OP_FEED_B64: begin
				emit_req   = !fb_b64 && bact_q && (blen >= OFS_W'(minb_q));
				emit_kind  = KIND_B64;
				emit_start = bbeg_q;
				emit_len   = blen;
			end
			OP_FEED_WIDE: begin
				emit_req   = wrep && (((wph_q == PH_LOW) && (fb != 8'h00)) ||
					((wph_q == PH_PAIR) && !fb_print));
				emit_kind  = KIND_WIDE;
				emit_start = wbeg_q;
				emit_len   = wlen;
			end
			OP_CLOSE_B64: begin
				emit_req   = bact_q && (cblen >= OFS_W'(minb_q));
				emit_kind  = KIND_B64;
				emit_start = bbeg_q;
				emit_len   = cblen;
			end
			OP_CLOSE_WIDE: begin
				emit_req   = wrep && ((wph_q == PH_LOW) || (wph_q == PH_PAIR));
				emit_kind  = KIND_WIDE;
				emit_start = wbeg_q;
				emit_len   = wlen;
			end
			OP_CLOSE_REGION: emit_req = 1'b1;
			default: emit_req = 1'b0;
		endcase
	end

	assign new_item.kind          = emit_kind;
	assign new_item.start_offset  = 32'(emit_start);
	assign new_item.length_bytes  = 32'(emit_len);
	assign new_item.last_of_batch = 1'b0;

	assign stat.sample_done = in_sample && (sample_last || in_data.end_of_file);
	assign stat.direct_feed = !in_sample && open_q && !skip_q;
	assign stat.text        = text;
	assign stat.region_open = open_q;
	assign stat.eof         = eof_q;
	assign stat.more        = (i_q != k_q[SMP_W-1:0]);

	assign out_valid = out_v_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (cmd.op == OP_ACCEPT && in_sample) mem[k_q[SMP_W-1:0]] <= in_data.data_byte;
		if (cmd.op == OP_READ) rdata_q <= mem[i_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_q   <= PCT_W'(60);
			alt_q    <= PCT_W'(25);
			zero_q   <= PCT_W'(25);
			minb_q   <= MINB_W'(24);
			minw_q   <= MINW_W'(16);
			pos_q    <= '0;
			k_q      <= '0;
			pc_q     <= '0;
			zc_q     <= '0;
			open_q   <= 1'b0;
			skip_q   <= 1'b0;
			rbeg_q   <= '0;
			bact_q   <= 1'b0;
			bbeg_q   <= '0;
			wbeg_q   <= '0;
			wch_q    <= '0;
			wph_q    <= PH_IDLE;
			eof_q    <= 1'b0;
			byte_q   <= '0;
			i_q      <= '0;
			rpos_q   <= '0;
			cend_q   <= '0;
			cnt_q    <= '0;
			pend_v_q <= 1'b0;
			pend_q   <= '0;
			out_v_q  <= 1'b0;
			out_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PRINT_MAIN: main_q <= cfg_data[PCT_W-1:0];
					REG_PRINT_ALT:  alt_q  <= cfg_data[PCT_W-1:0];
					REG_ZERO_ALT:   zero_q <= cfg_data[PCT_W-1:0];
					REG_MIN_B64:    minb_q <= cfg_data[MINB_W-1:0];
					REG_MIN_WIDE:   minw_q <= cfg_data[MINW_W-1:0];
					default: ;
				endcase
			end

			if (out_v_q && out_ready) out_v_q <= 1'b0;

			// Every descriptor is held back one place so the last of the batch can be marked.
			if (emit_req && (cnt_q < RES_W'(MAX_RESULTS))) begin
				cnt_q    <= cnt_q + 1'b1;
				pend_q   <= new_item;
				pend_v_q <= 1'b1;
				if (pend_v_q) begin
					out_q   <= pend_q;
					out_v_q <= 1'b1;
				end
			end

			case (cmd.op)
				OP_ACCEPT: begin
					byte_q <= in_data.data_byte;
					eof_q  <= in_data.end_of_file;
					if (k_first) skip_q <= 1'b0;
					if (in_sample) begin
						pc_q <= pc_base + CNT_W'(is_texty(in_data.data_byte));
						zc_q <= zc_base + CNT_W'(!is_texty(in_data.data_byte) &&
							(in_data.data_byte == 8'h00));
					end
				end
				OP_JUDGE: begin
					if (text) begin
						i_q <= '0;
						if (!open_q) begin
							open_q <= 1'b1;
							rbeg_q <= bstart;
							bact_q <= 1'b0;
							wph_q  <= PH_IDLE;
							wch_q  <= '0;
						end
					end else begin
						skip_q <= 1'b1;
						cend_q <= bstart;
					end
				end
				OP_READ: rpos_q <= bstart + OFS_W'(i_q);
				OP_FEED_B64: begin
					if (fb_b64) begin
						if (!bact_q) begin
							bact_q <= 1'b1;
							bbeg_q <= fpos;
						end
					end else bact_q <= 1'b0;
				end
				OP_FEED_WIDE: begin
					if (cmd.replay && stat.more) i_q <= i_q + 1'b1;
					if ((wph_q == PH_LOW) && (fb == 8'h00)) begin
						if (wch_q != {MINW_W{1'b1}}) wch_q <= wch_q + 1'b1;
						wph_q <= PH_PAIR;
					end else if ((wph_q == PH_PAIR) && fb_print) begin
						wph_q <= PH_LOW;
					end else if ((wph_q != PH_PAIR) && fb_print) begin
						wph_q  <= PH_LOW;
						wbeg_q <= fpos;
						wch_q  <= '0;
					end else begin
						wph_q <= PH_IDLE;
						wch_q <= '0;
					end
				end
				OP_CLOSE_REGION: begin
					open_q <= 1'b0;
					bact_q <= 1'b0;
					wph_q  <= PH_IDLE;
					wch_q  <= '0;
				end
				OP_FINISH: begin
					if (fin_close) begin
						cend_q <= pos_q + 1'b1;
					end else begin
						cnt_q <= '0;
						if (pend_v_q) begin
							out_q               <= pend_q;
							out_q.last_of_batch <= 1'b1;
							out_v_q             <= 1'b1;
							pend_v_q            <= 1'b0;
						end
						if (eof_q) begin
							pos_q  <= '0;
							k_q    <= '0;
							pc_q   <= '0;
							zc_q   <= '0;
							open_q <= 1'b0;
							skip_q <= 1'b0;
							rbeg_q <= '0;
							bact_q <= 1'b0;
							bbeg_q <= '0;
							wbeg_q <= '0;
							wch_q  <= '0;
							wph_q  <= PH_IDLE;
						end else begin
							pos_q <= pos_q + 1'b1;
							if (({1'b0, k_q} + 1'b1) >= (BLK_W+1)'(BLOCK_BYTES)) k_q <= '0;
							else k_q <= k_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== dv/tb_text_region_run_detector_unit.sv =====
// Testbench for text_region_run_detector_unit: streams files byte by byte, predicts the
// region, base64 and UTF-16LE descriptors in step and checks every output item in order.
// Depends on trrd_pkg and the unit itself.
`timescale 1ns / 1ps

module tb_text_region_run_detector_unit;
	import trrd_pkg::*;

	localparam int WATCH_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 2000;
	localparam int RANDOM_ITEMS = 200;

	typedef enum int {WIDE_IDLE, WIDE_LOW, WIDE_PAIR} wide_phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	text_region_run_detector_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Register copies.
	int unsigned pct_main = 60, pct_alt = 25, pct_zero = 25;
	int unsigned min_b64 = 24, min_wide = 16;

	// Detector state as the unit should hold it.
	logic [7:0] sample_bytes [SAMPLE_TAKE];
	logic [31:0] file_pos, region_start, b64_start, wide_start;
	int unsigned blk_off, print_cnt, zero_cnt, wide_chars, batch_n;
	bit region_on, skipping, b64_on;
	wide_phase_t wide_ph;

	out_item_t expected_desc[$];
	logic [7:0] file_q[$];
	int errors = 0;
	int items_sent = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	bit calm = 1'b0;

	task automatic report(input string msg);
		errors++;
		if (errors <= 40)
			$display("ERROR at %0t: %s", $time, msg);
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic bit b64_char(input logic [7:0] b);
		return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
			(b >= "0" && b <= "9") || b == "+" || b == "/" || b == "=";
	endfunction

	function automatic bit ascii_char(input logic [7:0] b);
		return b >= 8'h20 && b < 8'h7F;
	endfunction

	task automatic append_byte(input logic [7:0] b);
		file_q.insert(file_q.size(), b);
	endtask

	task automatic clear_state();
		file_pos = '0;
		blk_off = 0;
		print_cnt = 0;
		zero_cnt = 0;
		region_on = 1'b0;
		skipping = 1'b0;
		region_start = '0;
		b64_start = '0;
		b64_on = 1'b0;
		wide_start = '0;
		wide_chars = 0;
		wide_ph = WIDE_IDLE;
	endtask

	task automatic push_desc(input logic [1:0] kind, input logic [31:0] start,
			input logic [31:0] len);
		out_item_t d;
		if (batch_n >= MAX_RESULTS) return;
		d.kind = kind;
		d.start_offset = start;
		d.length_bytes = len;
		d.last_of_batch = 1'b0;
		expected_desc.insert(expected_desc.size(), d);
		batch_n++;
	endtask

	task automatic wide_emit(input logic [31:0] end_pos);
		if (wide_chars > 0 && wide_chars >= min_wide)
			push_desc(KIND_WIDE, wide_start, end_pos - wide_start);
	endtask

	task automatic wide_restart(input logic [7:0] b, input logic [31:0] pos);
		wide_chars = 0;
		if (ascii_char(b)) begin
			wide_ph = WIDE_LOW;
			wide_start = pos;
		end else begin
			wide_ph = WIDE_IDLE;
		end
	endtask

	task automatic track_byte(input logic [7:0] b, input logic [31:0] pos);
		if (b64_char(b)) begin
			if (!b64_on) begin
				b64_on = 1'b1;
				b64_start = pos;
			end
		end else if (b64_on) begin
			if (pos - b64_start >= min_b64)
				push_desc(KIND_B64, b64_start, pos - b64_start);
			b64_on = 1'b0;
		end
		case (wide_ph)
			WIDE_LOW: begin
				if (b == 8'h00) begin
					if (wide_chars < 4095) wide_chars++;
					wide_ph = WIDE_PAIR;
				end else begin
					wide_emit(pos - 32'd1);
					wide_restart(b, pos);
				end
			end
			WIDE_PAIR: begin
				if (ascii_char(b)) begin
					wide_ph = WIDE_LOW;
				end else begin
					wide_emit(pos);
					wide_ph = WIDE_IDLE;
					wide_chars = 0;
				end
			end
			default: wide_restart(b, pos);
		endcase
	endtask

	task automatic close_region(input logic [31:0] end_pos);
		if (b64_on && end_pos - b64_start >= min_b64)
			push_desc(KIND_B64, b64_start, end_pos - b64_start);
		if (wide_ph == WIDE_PAIR) wide_emit(end_pos);
		else if (wide_ph == WIDE_LOW) wide_emit(end_pos - 32'd1);
		push_desc(KIND_REGION, region_start, end_pos - region_start);
		region_on = 1'b0;
		b64_on = 1'b0;
		wide_ph = WIDE_IDLE;
		wide_chars = 0;
	endtask

	// Works out the descriptors that one accepted byte causes.
	task automatic predict_byte(input logic [7:0] b, input bit eof);
		logic [31:0] pos, blk_start;
		int unsigned k, take;
		bit text;
		int first;
		out_item_t d;
		pos = file_pos;
		k = blk_off;
		first = expected_desc.size();
		batch_n = 0;
		if (k == 0) begin
			print_cnt = 0;
			zero_cnt = 0;
			skipping = 1'b0;
		end
		if (k < SAMPLE_TAKE) begin
			sample_bytes[k] = b;
			if (b == 8'h09 || b == 8'h0A || b == 8'h0D || ascii_char(b)) print_cnt++;
			else if (b == 8'h00) zero_cnt++;
			if (k + 1 == SAMPLE_TAKE || eof) begin
				take = k + 1;
				text = (print_cnt * 100 >= take * pct_main) ||
					(print_cnt * 100 >= take * pct_alt && zero_cnt * 100 >= take * pct_zero);
				blk_start = pos - k;
				if (text) begin
					if (!region_on) begin
						region_on = 1'b1;
						region_start = blk_start;
						b64_on = 1'b0;
						wide_ph = WIDE_IDLE;
						wide_chars = 0;
					end
					for (int i = 0; i <= k; i++)
						track_byte(sample_bytes[i], blk_start + 32'(i));
				end else begin
					if (region_on) close_region(blk_start);
					skipping = 1'b1;
				end
			end
		end else if (region_on && !skipping) begin
			track_byte(b, pos);
		end
		if (eof) begin
			if (region_on) close_region(pos + 32'd1);
			clear_state();
		end else begin
			file_pos = pos + 32'd1;
			blk_off = (k + 1 >= BLOCK_BYTES) ? 0 : k + 1;
		end
		if (expected_desc.size() > first) begin
			d = expected_desc[expected_desc.size() - 1];
			d.last_of_batch = 1'b1;
			expected_desc[expected_desc.size() - 1] = d;
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input bit eof);
		int gap;
		gap = calm ? 0 : gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{data_byte: b, end_of_file: eof};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
		predict_byte(b, eof);
	endtask

	task automatic send_file();
		foreach (file_q[i])
			send_byte(file_q[i], i == file_q.size() - 1);
	endtask

	// Lets every descriptor arrive, then lets a pending replay finish.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_desc.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_PRINT_MAIN: pct_main = val & 32'h7F;
			REG_PRINT_ALT: pct_alt = val & 32'h7F;
			REG_ZERO_ALT: pct_zero = val & 32'h7F;
			REG_MIN_B64: min_b64 = val & 32'h1FFF;
			REG_MIN_WIDE: min_wide = val & 32'hFFF;
			default: ;
		endcase
	endtask

	// Appends one stretch of text-like content: runs, wide strings, spacing or noise.
	task automatic add_segment();
		string alpha;
		int n;
		alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/=";
		case ($urandom_range(0, 5))
			0: begin
				n = $urandom_range(1, 30);
				repeat (n) append_byte(alpha[$urandom_range(0, alpha.len() - 1)]);
			end
			1: begin
				n = $urandom_range(1, 20);
				repeat (n) begin
					append_byte(8'($urandom_range(8'h20, 8'h7E)));
					append_byte(8'h00);
				end
				if ($urandom_range(0, 2) == 0) append_byte(8'($urandom_range(8'h20, 8'h7E)));
			end
			2: repeat ($urandom_range(1, 3)) append_byte($urandom_range(0, 1) ? " " : 8'h0A);
			3: repeat ($urandom_range(1, 3)) append_byte(8'($urandom));
			4: repeat ($urandom_range(1, 4)) append_byte(8'h00);
			default: repeat ($urandom_range(1, 4)) append_byte(8'($urandom_range(8'h21, 8'h2F)));
		endcase
	endtask

	task automatic test_directed();
		file_q = '{8'h00, 8'hFF, "A", "=", "a", 8'h00, "b", 8'h00, 8'h09, 8'h7F, 8'h0D, " "};
		send_file();
		file_q = '{"Q"};
		send_file();
		file_q = '{8'h80, 8'hC3, 8'h01, 8'h7F};
		send_file();
		wait_idle();
	endtask

	task automatic test_thresholds();
		write_reg(REG_MIN_B64, 1);
		write_reg(REG_MIN_WIDE, 1);
		write_reg(REG_PRINT_MAIN, 0);
		file_q = '{8'hFE, 8'h81, 8'h02};
		send_file();
		wait_idle();
		write_reg(REG_PRINT_MAIN, 127);
		write_reg(REG_PRINT_ALT, 0);
		write_reg(REG_ZERO_ALT, 0);
		file_q = '{8'h90, "x", 8'h00};
		send_file();
		wait_idle();
		write_reg(REG_ZERO_ALT, 100);
		file_q = '{8'h00, 8'h00, 8'h00};
		send_file();
		wait_idle();
		write_reg(REG_PRINT_ALT, 127);
		file_q = '{"a", "b", 8'h00};
		send_file();
		wait_idle();
	endtask

	// More descriptors at one byte than a batch holds: the excess is dropped.
	task automatic test_batch_overflow();
		write_reg(REG_PRINT_MAIN, 60);
		write_reg(REG_PRINT_ALT, 25);
		write_reg(REG_ZERO_ALT, 25);
		write_reg(REG_MIN_B64, 0);
		write_reg(REG_MIN_WIDE, 0);
		file_q.delete();
		repeat (70) begin
			append_byte("A");
			append_byte(" ");
		end
		send_file();
		wait_idle();
	endtask

	task automatic test_random();
		int files;
		files = 0;
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if (files % 5 == 0) begin
				wait_idle();
				write_reg(REG_PRINT_MAIN, $urandom_range(0, 3) == 0 ? 100 : $urandom_range(30, 80));
				write_reg(REG_PRINT_ALT, $urandom_range(0, 60));
				write_reg(REG_ZERO_ALT, $urandom_range(0, 4) == 0 ? 127 : $urandom_range(0, 50));
				write_reg(REG_MIN_B64, $urandom_range(0, 9) == 0 ? 8191 : $urandom_range(1, 12));
				write_reg(REG_MIN_WIDE, $urandom_range(0, 9) == 0 ? 4095 : $urandom_range(1, 6));
			end
			file_q.delete();
			if ($urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(1, 40)) append_byte(8'($urandom));
			end else begin
				while (file_q.size() < $urandom_range(4, 60)) add_segment();
			end
			send_file();
			files++;
		end
		wait_idle();
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (out_valid && out_ready) begin
			if (expected_desc.size() == 0) begin
				report($sformatf("descriptor with none expected: kind %0d start %0d len %0d",
					out_data.kind, out_data.start_offset, out_data.length_bytes));
			end else begin
				want = expected_desc.pop_front();
				if (out_data.kind !== want.kind)
					report($sformatf("kind %0d, expected %0d", out_data.kind, want.kind));
				if (out_data.start_offset !== want.start_offset)
					report($sformatf("start_offset %0d, expected %0d",
						out_data.start_offset, want.start_offset));
				if (out_data.length_bytes !== want.length_bytes)
					report($sformatf("length_bytes %0d, expected %0d",
						out_data.length_bytes, want.length_bytes));
				if (out_data.last_of_batch !== want.last_of_batch)
					report($sformatf("last_of_batch %0d, expected %0d",
						out_data.last_of_batch, want.last_of_batch));
			end
		end
		// Calm stretches switch idling off on both sides.
		if ($urandom_range(0, 499) == 0) calm = !calm;
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (!calm && $urandom_range(0, 3) == 0) stall_left = gap_len();
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCH_LIMIT) begin
					$display("Mismatches found");
					$finish;
				end
			end
		end
	end

	initial begin
		clear_state();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_thresholds();
		test_batch_overflow();
		test_random();
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
